/* rtl/biou_pkg.sv */
package biou_pkg;

  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned DistFracBitsDefault = 16;

endpackage

/* rtl/biou_area.sv */
module biou_area import biou_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] track_x_i,
  input  logic signed [COORD_BITS-1:0] track_y_i,
  input  logic        [COORD_BITS-1:0] track_w_i,
  input  logic        [COORD_BITS-1:0] track_h_i,
  input  logic signed [COORD_BITS-1:0] det_x_i,
  input  logic signed [COORD_BITS-1:0] det_y_i,
  input  logic        [COORD_BITS-1:0] det_w_i,
  input  logic        [COORD_BITS-1:0] det_h_i,
  output logic                         valid_o,
  output logic [2*COORD_BITS-1:0]      inter_o,
  output logic [2*COORD_BITS+1:0]      union_o
);

  localparam int unsigned EW = COORD_BITS + 2;
  localparam int unsigned AW = 2 * COORD_BITS;

  // stage 1: right/bottom edges and overlap extents
  logic signed [EW-1:0] tx0, ty0, dx0, dy0, tx1, ty1, dx1, dy1;
  logic signed [EW-1:0] lox, hix, loy, hiy, ovx, ovy;
  logic [COORD_BITS-1:0] iw_d, ih_d, iw_q, ih_q;
  logic [COORD_BITS-1:0] tw_q, th_q, dw_q, dh_q;
  logic v1_q;

  always_comb begin
    tx0 = EW'(track_x_i);
    ty0 = EW'(track_y_i);
    dx0 = EW'(det_x_i);
    dy0 = EW'(det_y_i);
    tx1 = tx0 + $signed({2'b00, track_w_i});
    ty1 = ty0 + $signed({2'b00, track_h_i});
    dx1 = dx0 + $signed({2'b00, det_w_i});
    dy1 = dy0 + $signed({2'b00, det_h_i});
    lox = (tx0 > dx0) ? tx0 : dx0;
    hix = (tx1 < dx1) ? tx1 : dx1;
    loy = (ty0 > dy0) ? ty0 : dy0;
    hiy = (ty1 < dy1) ? ty1 : dy1;
    ovx = hix - lox;
    ovy = hiy - loy;
    iw_d = (hix > lox) ? ovx[COORD_BITS-1:0] : '0;
    ih_d = (hiy > loy) ? ovy[COORD_BITS-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      iw_q <= iw_d; ih_q <= ih_d;
      tw_q <= track_w_i; th_q <= track_h_i;
      dw_q <= det_w_i; dh_q <= det_h_i;
    end
  end

  // stage 2: three area products
  logic [AW-1:0] ai_q, at_q, ad_q;
  logic v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ai_q <= AW'(iw_q) * AW'(ih_q);
      at_q <= AW'(tw_q) * AW'(th_q);
      ad_q <= AW'(dw_q) * AW'(dh_q);
    end
  end

  // stage 3: union area
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inter_o <= ai_q;
      union_o <= {2'b00, at_q} + {2'b00, ad_q} - {2'b00, ai_q};
    end
  end

endmodule

/* rtl/biou_div.sv */
module biou_div import biou_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault,
  parameter int unsigned DIST_FRAC_BITS = DistFracBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2*COORD_BITS-1:0]   inter_i,
  input  logic [2*COORD_BITS+1:0]   union_i,
  output logic                      valid_o,
  output logic [DIST_FRAC_BITS:0]   distance_o,
  output logic                      empty_union_o
);

  localparam int unsigned UW = 2 * COORD_BITS + 2;
  localparam int unsigned RW = UW + 1;
  localparam int unsigned NS = DIST_FRAC_BITS + 2;
  localparam int unsigned QW = DIST_FRAC_BITS + 2;

  // one restoring step per stage; stage 0 is the integer bit
  logic [RW-1:0] r_q [NS];
  logic [UW-1:0] u_q [NS];
  logic [QW-1:0] q_q [NS];
  logic          z_q [NS];
  logic          v_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_step
    logic [RW-1:0] r_in, r_sub;
    logic [UW-1:0] u_in;
    logic [QW-1:0] q_in;
    logic          z_in, v_in, ge;

    if (s == 0) begin : g_first
      assign r_in = RW'(inter_i);
      assign u_in = union_i;
      assign q_in = '0;
      assign z_in = (union_i == '0);
      assign v_in = valid_i;
    end else begin : g_next
      assign r_in = {r_q[s-1][RW-2:0], 1'b0};
      assign u_in = u_q[s-1];
      assign q_in = {q_q[s-1][QW-2:0], 1'b0};
      assign z_in = z_q[s-1];
      assign v_in = v_q[s-1];
    end

    assign ge    = (r_in >= {1'b0, u_in});
    assign r_sub = r_in - {1'b0, u_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s] <= 1'b0;
      else if (en_i) v_q[s] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= ge ? r_sub : r_in;
        u_q[s] <= u_in;
        q_q[s] <= {q_in[QW-1:1], ge};
        z_q[s] <= z_in;
      end
    end
  end

  // round half up, clamp, subtract from one; an empty union gives one
  localparam logic [QW-1:0] One = QW'(1) << DIST_FRAC_BITS;
  logic [QW-1:0] iou_r, iou_c;
  logic [QW-1:0] dist_full;

  always_comb begin
    iou_r = (q_q[NS-1] + QW'(1)) >> 1;
    iou_c = (iou_r > One) ? One : iou_r;
    dist_full = z_q[NS-1] ? One : (One - iou_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= v_q[NS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      distance_o    <= dist_full[DIST_FRAC_BITS:0];
      empty_union_o <= z_q[NS-1];
    end
  end

endmodule

/* rtl/box_iou_distance_core.sv */
// box pair to 1 - IoU distance, fully pipelined
//
// input channel: valid_i / stall_o with eight box fields, one pair a beat
// output channel: valid_o / stall_i with distance_o (Q1.DIST_FRAC_BITS,
// 2^DIST_FRAC_BITS is 1.0) and empty_union_o
//
// throughput is one beat per cycle while the output is not stalled; the path
// holds three area stages, DIST_FRAC_BITS + 2 restoring divide stages (one
// quotient bit each), and one rounding stage
//
// the pipeline advances as a whole while the output is empty or taken;
// when stall_i holds a waiting result, every stage freezes and stall_o
// rises, so nothing is lost or repeated
//
// reset clears all valid bits; the block holds no state between pairs
module box_iou_distance_core import biou_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault,
  parameter int unsigned DIST_FRAC_BITS = DistFracBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [COORD_BITS-1:0] track_x_i,
  input  logic signed [COORD_BITS-1:0] track_y_i,
  input  logic        [COORD_BITS-1:0] track_w_i,
  input  logic        [COORD_BITS-1:0] track_h_i,
  input  logic signed [COORD_BITS-1:0] det_x_i,
  input  logic signed [COORD_BITS-1:0] det_y_i,
  input  logic        [COORD_BITS-1:0] det_w_i,
  input  logic        [COORD_BITS-1:0] det_h_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [DIST_FRAC_BITS:0]      distance_o,
  output logic                         empty_union_o
);

  logic en;
  logic av;
  logic [2*COORD_BITS-1:0] inter;
  logic [2*COORD_BITS+1:0] uni;

  // global advance
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  biou_area #(.COORD_BITS(COORD_BITS)) u_area (
    .clk_i, .rst_ni, .en_i(en), .valid_i,
    .track_x_i, .track_y_i, .track_w_i, .track_h_i,
    .det_x_i, .det_y_i, .det_w_i, .det_h_i,
    .valid_o(av), .inter_o(inter), .union_o(uni)
  );

  biou_div #(.COORD_BITS(COORD_BITS), .DIST_FRAC_BITS(DIST_FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(av),
    .inter_i(inter), .union_i(uni),
    .valid_o, .distance_o, .empty_union_o
  );

`ifndef SYNTHESIS
  localparam logic [DIST_FRAC_BITS:0] OneD = (DIST_FRAC_BITS+1)'(1) << DIST_FRAC_BITS;

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> distance_o <= OneD)
    else $error("distance above one");

  a_empty_is_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && empty_union_o) |-> distance_o == OneD)
    else $error("empty union without unit distance");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o && $stable(distance_o))
    else $error("held result changed");
`endif

endmodule
